### sv/hciu_pkg.sv
package hciu_pkg;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_PRE  = 2'd1,
      PH_PAY  = 2'd2
   } phase_type;

   localparam int unsigned ByteW = 8;
   localparam int unsigned KindW = 3;
   localparam int unsigned LenW  = 16;
   localparam int unsigned IdxW  = 3;
   localparam int unsigned UserW = 5;

   localparam logic [KindW-1:0] KIND_NONE  = 3'd0;
   localparam logic [KindW-1:0] KIND_CMD   = 3'd1;
   localparam logic [KindW-1:0] KIND_ACL   = 3'd2;
   localparam logic [KindW-1:0] KIND_SCO   = 3'd3;
   localparam logic [KindW-1:0] KIND_EVENT = 3'd4;
   localparam logic [KindW-1:0] KIND_ISO   = 3'd5;

   localparam logic [3:0] IsoLenHiMask = 4'hf;

   // preamble size per packet kind, zero for kinds that mean nothing
   function automatic logic [IdxW-1:0] pre_size(input logic [KindW-1:0] k);
      logic [IdxW-1:0] sz;
      unique case (k)
         KIND_CMD:   sz = 3'd3;
         KIND_ACL:   sz = 3'd4;
         KIND_SCO:   sz = 3'd3;
         KIND_EVENT: sz = 3'd2;
         KIND_ISO:   sz = 3'd4;
         default:    sz = 3'd0;
      endcase
      return sz;
   endfunction

   // preamble offset of the (low) length byte
   function automatic logic [IdxW-1:0] len_pos(input logic [KindW-1:0] k);
      logic [IdxW-1:0] pos;
      unique case (k)
         KIND_CMD, KIND_ACL, KIND_SCO, KIND_ISO: pos = 3'd2;
         KIND_EVENT:                             pos = 3'd1;
         default:                                pos = 3'd0;
      endcase
      return pos;
   endfunction

endpackage

### sv/hci_uart_packet_deframer_top.sv
// A result appears on the rsp_ side in the cycle after its byte is accepted.
// Throughput: one byte per cycle while rsp_ is not stalled; the next per-byte state
// (phase, preamble index, 16-bit remaining count) is worked out combinationally.
// A type byte of 1 to 5 is consumed without a result.
// Reset (synchronous, active high) returns to waiting for a type byte and
// empties the result register.
module hci_uart_packet_deframer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [hciu_pkg::ByteW-1:0]   req_tdata,   // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [hciu_pkg::ByteW-1:0]   rsp_tdata,   // [7:0] packet_byte
   output logic [hciu_pkg::UserW-1:0]   rsp_tuser,   // [2:0] packet_kind, [3] first_of_packet,
                                                     // [4] bad_type
   output logic                         rsp_tlast    // last_of_packet
);

   hciu_pkg::phase_type            phase_ff, phase_in;
   logic [hciu_pkg::KindW-1:0]     kind_ff, kind_in;
   logic [hciu_pkg::LenW-1:0]      remain_ff, remain_in;
   logic [hciu_pkg::ByteW-1:0]     len_low_ff, len_low_in;
   logic [hciu_pkg::IdxW-1:0]      pre_idx_ff, pre_idx_in;

   logic                           out_valid_ff, out_valid_in;
   logic [hciu_pkg::ByteW-1:0]     out_byte_ff, out_byte_in;
   logic [hciu_pkg::KindW-1:0]     out_kind_ff, out_kind_in;
   logic                           out_first_ff, out_first_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_bad_ff, out_bad_in;

   logic                           accept;
   logic                           emit;
   logic [hciu_pkg::IdxW-1:0]      psize;
   logic [hciu_pkg::IdxW:0]        idx_next;
   logic [hciu_pkg::LenW-1:0]      pkt_len;
   logic [hciu_pkg::LenW-1:0]      remain_dec;
   logic [hciu_pkg::ByteW-1:0]     b;

   assign req_tready = ~out_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign b          = req_tdata;
   assign psize      = hciu_pkg::pre_size(kind_ff);
   assign idx_next   = {1'b0, pre_idx_ff} + 4'd1;
   assign remain_dec = remain_ff - 16'd1;

   always_comb begin
      priority if (kind_ff == hciu_pkg::KIND_ACL) begin
         pkt_len = {b, len_low_ff};
      end else if (kind_ff == hciu_pkg::KIND_ISO) begin
         pkt_len = {4'd0, b[3:0] & hciu_pkg::IsoLenHiMask, len_low_ff};
      end else begin
         pkt_len = {8'd0, b};
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      remain_in    = remain_ff;
      len_low_in   = len_low_ff;
      pre_idx_in   = pre_idx_ff;
      emit         = 1'b1;
      out_byte_in  = b;
      out_kind_in  = kind_ff;
      out_first_in = 1'b0;
      out_last_in  = 1'b0;
      out_bad_in   = 1'b0;

      priority if (phase_ff == hciu_pkg::PH_PRE && psize != 3'd0) begin
         out_first_in = (pre_idx_ff == 3'd0);
         if (pre_idx_ff == hciu_pkg::len_pos(kind_ff)) begin
            len_low_in = b;
         end
         if (idx_next >= {1'b0, psize}) begin
            pre_idx_in = 3'd0;
            if (pkt_len == 16'd0) begin
               phase_in    = hciu_pkg::PH_TYPE;
               kind_in     = hciu_pkg::KIND_NONE;
               out_last_in = 1'b1;
            end else begin
               remain_in = pkt_len;
               phase_in  = hciu_pkg::PH_PAY;
            end
         end else begin
            pre_idx_in = idx_next[hciu_pkg::IdxW-1:0];
         end
      end else if (phase_ff == hciu_pkg::PH_PAY && psize != 3'd0 && remain_ff != 16'd0) begin
         remain_in = remain_dec;
         if (remain_dec == 16'd0) begin
            phase_in    = hciu_pkg::PH_TYPE;
            kind_in     = hciu_pkg::KIND_NONE;
            out_last_in = 1'b1;
         end
      end else begin
         // waiting for a type byte, also any unused state
         pre_idx_in = 3'd0;
         remain_in  = 16'd0;
         if (b >= 8'd1 && b <= 8'd5) begin
            kind_in  = b[hciu_pkg::KindW-1:0];
            phase_in = hciu_pkg::PH_PRE;
            emit     = 1'b0;
         end else begin
            kind_in     = hciu_pkg::KIND_NONE;
            phase_in    = hciu_pkg::PH_TYPE;
            out_kind_in = hciu_pkg::KIND_NONE;
            out_bad_in  = 1'b1;
         end
      end
   end

   // hold the result until taken; replace it only on a new accept
   always_comb begin
      if (accept) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff & ~rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hciu_pkg::PH_TYPE;
         kind_ff      <= hciu_pkg::KIND_NONE;
         remain_ff    <= '0;
         len_low_ff   <= '0;
         pre_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            kind_ff    <= kind_in;
            remain_ff  <= remain_in;
            len_low_ff <= len_low_in;
            pre_idx_ff <= pre_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_byte_ff  <= out_byte_in;
         out_kind_ff  <= out_kind_in;
         out_first_ff <= out_first_in;
         out_last_ff  <= out_last_in;
         out_bad_ff   <= out_bad_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_bad_ff, out_first_ff, out_kind_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

### sv/hciu_checker.sv
module hciu_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [hciu_pkg::ByteW-1:0]   rsp_tdata,
   input logic [hciu_pkg::UserW-1:0]   rsp_tuser,
   input logic                         rsp_tlast
);

   // stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // a bad type result carries no kind and no packet marks
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[4] |->
         rsp_tuser[2:0] == hciu_pkg::KIND_NONE && !rsp_tuser[3] && !rsp_tlast)
      else $error("bad type result with packet fields set");

   // a packet byte always names a real kind
   a_good_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[4] |->
         rsp_tuser[2:0] == hciu_pkg::KIND_CMD || rsp_tuser[2:0] == hciu_pkg::KIND_ACL ||
         rsp_tuser[2:0] == hciu_pkg::KIND_SCO || rsp_tuser[2:0] == hciu_pkg::KIND_EVENT ||
         rsp_tuser[2:0] == hciu_pkg::KIND_ISO)
      else $error("packet byte with invalid kind");

   // a transaction taken while no byte comes in leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result repeated after it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind hci_uart_packet_deframer_top hciu_checker u_hciu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
